// ===== src/pfr_pkg.sv =====
// ---------------------------------------------------------------------------
// Rotating Playfair package
// Shared types, codes, reset values and square fill tables.
// ---------------------------------------------------------------------------
package pfr_pkg;

   localparam int SIDE = 5;
   localparam int CELLS = 25;
   localparam int KEY_COUNT = 25;
   localparam int KEY_BITS = 125;
   localparam int CSR_WIDTH = 45;

   typedef logic [4:0] pfr_letter_type;
   typedef logic [SIDE-1:0] pfr_onehot_type;

   localparam pfr_letter_type LETTER_I = 5'd8;
   localparam pfr_letter_type LETTER_J = 5'd9;
   localparam pfr_letter_type LETTER_Z = 5'd25;

   typedef enum logic [1:0] {
      CMD_RESTART = 2'd0,
      CMD_ENCRYPT = 2'd1,
      CMD_DECRYPT = 2'd2
   } pfr_command_type;

   typedef enum logic [2:0] {
      CSR_KEY_FIRST  = 3'd0,
      CSR_KEY_MIDDLE = 3'd1,
      CSR_KEY_LAST   = 3'd2,
      CSR_FILL_ORDER = 3'd3,
      CSR_PERIOD     = 3'd4
   } pfr_csr_type;

   typedef enum logic [1:0] {
      ORDER_ROW    = 2'd0,
      ORDER_COLUMN = 2'd1,
      ORDER_SPIRAL = 2'd2
   } pfr_order_type;

   localparam logic [44:0] KEY_FIRST_RESET  = 45'd1103318704266;
   localparam logic [44:0] KEY_MIDDLE_RESET = 45'd16952613640354;
   localparam logic [34:0] KEY_LAST_RESET   = 35'd27637993040;
   localparam logic [9:0]  PERIOD_RESET     = 10'd5;

   localparam pfr_letter_type COLUMN_SLOT [CELLS] = '{
      5'd0, 5'd5, 5'd10, 5'd15, 5'd20,
      5'd1, 5'd6, 5'd11, 5'd16, 5'd21,
      5'd2, 5'd7, 5'd12, 5'd17, 5'd22,
      5'd3, 5'd8, 5'd13, 5'd18, 5'd23,
      5'd4, 5'd9, 5'd14, 5'd19, 5'd24
   };

   localparam pfr_letter_type SPIRAL_SLOT [CELLS] = '{
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4,
      5'd9, 5'd14, 5'd19, 5'd24, 5'd23,
      5'd22, 5'd21, 5'd20, 5'd15, 5'd10,
      5'd5, 5'd6, 5'd7, 5'd8, 5'd13,
      5'd18, 5'd17, 5'd16, 5'd11, 5'd12
   };

   typedef struct packed {
      logic           wr;
      pfr_letter_type slot;
      pfr_letter_type letter;
   } pfr_fill_type;

   typedef struct packed {
      pfr_onehot_type row1;
      pfr_onehot_type col1;
      pfr_onehot_type row2;
      pfr_onehot_type col2;
   } pfr_target_type;

   function automatic pfr_letter_type fill_slot(input logic [1:0] order,
                                                input pfr_letter_type index);
      pfr_letter_type slot;
      unique case (order)
         ORDER_ROW:    slot = index;
         ORDER_COLUMN: slot = COLUMN_SLOT[index];
         default:      slot = SPIRAL_SLOT[index];
      endcase
      return slot;
   endfunction

   // Moves a one-hot position by one place, forward or backward, around five.
   function automatic pfr_onehot_type shift_onehot(input pfr_onehot_type pos,
                                                   input logic backward);
      pfr_onehot_type moved;
      if (backward) begin
         moved = {pos[0], pos[SIDE-1:1]};
      end else begin
         moved = {pos[SIDE-2:0], pos[SIDE-1]};
      end
      return moved;
   endfunction

endpackage

// ===== src/pfr_builder.sv =====
// ---------------------------------------------------------------------------
// Square builder
// Walks the key letters and then the alphabet, one letter a cycle, and
// places each new letter in the next slot of the selected fill order.
// ---------------------------------------------------------------------------
module pfr_builder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [pfr_pkg::KEY_BITS-1:0]    start_keys,
   input  logic [1:0]                      start_order,
   output logic                            busy,
   output pfr_pkg::pfr_fill_type           fill
);
   import pfr_pkg::*;

   localparam int LAST_STEP = KEY_COUNT + 26 - 1;

   logic                busy_ff, busy_in;
   logic [5:0]          step_ff, step_in;
   logic [4:0]          count_ff, count_in;
   logic [25:0]         used_ff, used_in;
   logic [KEY_BITS-1:0] keys_ff, keys_in;
   logic [1:0]          order_ff, order_in;

   logic           from_key;
   pfr_letter_type raw;
   pfr_letter_type code;
   logic           seen;
   logic           take;

   always_comb begin
      from_key = step_ff < 6'(KEY_COUNT);
      raw = from_key ? keys_ff[4:0] : 5'(step_ff - 6'(KEY_COUNT));
      code = (from_key && raw == LETTER_J) ? LETTER_I : raw;
      seen = 1'b0;
      if (code <= LETTER_Z) begin
         seen = used_ff[code];
      end
      take = busy_ff && (code <= LETTER_Z) && !seen && !(!from_key && raw == LETTER_J)
             && (count_ff < 5'(CELLS));

      fill.wr = take;
      fill.slot = fill_slot(order_ff, count_ff);
      fill.letter = code;

      busy_in = busy_ff;
      step_in = step_ff;
      count_in = count_ff;
      used_in = used_ff;
      keys_in = keys_ff;
      order_in = order_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         count_in = '0;
         used_in = '0;
         keys_in = start_keys;
         order_in = start_order;
      end else if (busy_ff) begin
         keys_in = keys_ff >> 5;
         step_in = step_ff + 6'd1;
         if (take) begin
            used_in[code] = 1'b1;
            count_in = count_ff + 5'd1;
         end
         if (step_ff == 6'(LAST_STEP)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
         count_ff <= '0;
         used_ff <= '0;
         keys_ff <= {KEY_LAST_RESET, KEY_MIDDLE_RESET, KEY_FIRST_RESET};
         order_ff <= ORDER_ROW;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         count_ff <= count_in;
         used_ff <= used_in;
         keys_ff <= keys_in;
         order_ff <= order_in;
      end
   end

   assign busy = busy_ff;

endmodule

// ===== src/pfr_lane.sv =====
// ---------------------------------------------------------------------------
// Square lane
// One cell of the square: matches both digraph letters and offers its
// letter when it is chosen as an output position.
// ---------------------------------------------------------------------------
module pfr_lane (
   input  pfr_pkg::pfr_letter_type letter,
   input  pfr_pkg::pfr_letter_type first_in,
   input  pfr_pkg::pfr_letter_type second_in,
   input  logic                    pick_first,
   input  logic                    pick_second,
   output logic                    hit_first,
   output logic                    hit_second,
   output pfr_pkg::pfr_letter_type first_pick,
   output pfr_pkg::pfr_letter_type second_pick
);
   import pfr_pkg::*;

   assign hit_first = letter == first_in;
   assign hit_second = letter == second_in;
   assign first_pick = pick_first ? letter : '0;
   assign second_pick = pick_second ? letter : '0;

endmodule

// ===== src/pfr_merge.sv =====
// ---------------------------------------------------------------------------
// Lane merge
// Reduces the lane matches to row and column positions, applies the
// same-row, same-column or rectangle rule and collects the chosen letters.
// ---------------------------------------------------------------------------
module pfr_merge (
   input  logic [pfr_pkg::CELLS-1:0]                         hit_first,
   input  logic [pfr_pkg::CELLS-1:0]                         hit_second,
   input  logic                                              decrypt,
   input  pfr_pkg::pfr_letter_type [pfr_pkg::CELLS-1:0]      first_picks,
   input  pfr_pkg::pfr_letter_type [pfr_pkg::CELLS-1:0]      second_picks,
   output pfr_pkg::pfr_target_type                           target,
   output pfr_pkg::pfr_letter_type                           first_out,
   output pfr_pkg::pfr_letter_type                           second_out
);
   import pfr_pkg::*;

   pfr_onehot_type row1, col1, row2, col2;

   always_comb begin
      row1 = '0;
      col1 = '0;
      row2 = '0;
      col2 = '0;
      for (int r = 0; r < SIDE; r++) begin
         for (int c = 0; c < SIDE; c++) begin
            row1[r] = row1[r] | hit_first[r*SIDE + c];
            col1[c] = col1[c] | hit_first[r*SIDE + c];
            row2[r] = row2[r] | hit_second[r*SIDE + c];
            col2[c] = col2[c] | hit_second[r*SIDE + c];
         end
      end

      priority if (row1 == row2) begin
         target.row1 = row1;
         target.col1 = shift_onehot(col1, decrypt);
         target.row2 = row2;
         target.col2 = shift_onehot(col2, decrypt);
      end else if (col1 == col2) begin
         target.row1 = shift_onehot(row1, decrypt);
         target.col1 = col1;
         target.row2 = shift_onehot(row2, decrypt);
         target.col2 = col2;
      end else begin
         target.row1 = row1;
         target.col1 = col2;
         target.row2 = row2;
         target.col2 = col1;
      end

      first_out = '0;
      second_out = '0;
      for (int k = 0; k < CELLS; k++) begin
         first_out = first_out | first_picks[k];
         second_out = second_out | second_picks[k];
      end
   end

endmodule

// ===== src/rotating_playfair_digraph_cipher.sv =====
// ---------------------------------------------------------------------------
// Rotating Playfair digraph cipher
// Playfair cipher on a 5x5 square whose rows rotate every few digraphs.
// ---------------------------------------------------------------------------
// An encrypt or decrypt item is taken every cycle while no build runs and the
// skid register is empty; its result is registered in the output register, or
// in the skid register while the output waits, so a two-deep output stage
// takes one more item while a result waits. The square lives in flip-flops and
// each of its 25 cells is a lane that matches and selects letters in parallel,
// so the lookup, substitution and row rotation all finish combinationally. A
// restart item hands the square to the builder, which takes one letter per
// cycle over 25 key letters and 26 alphabet codes: input is held off while it
// runs after a restart or reset, while configuration writes are still taken.
module rotating_playfair_digraph_cipher #(
   parameter int MAX_PERIOD = 1000
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [15:0]                      req_tdata,  // first_letter, second_letter
   input  logic [1:0]                       req_tuser,  // command
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,  // first_out, second_out, rotated
   input  logic                             csr_we,
   input  logic [2:0]                       csr_index,
   input  logic [pfr_pkg::CSR_WIDTH-1:0]    csr_wdata
);
   import pfr_pkg::*;

   localparam int PERIOD_CAP = (MAX_PERIOD < 1023) ? MAX_PERIOD : 1023;
   localparam int CW = (PERIOD_CAP < 2) ? 1 : $clog2(PERIOD_CAP + 1);

   logic [44:0] key_first_ff;
   logic [44:0] key_middle_ff;
   logic [34:0] key_last_ff;
   logic [1:0]  fill_order_ff;
   logic [9:0]  period_ff;

   pfr_letter_type square_ff [CELLS];
   logic [CW-1:0]  count_ff, count_in;
   logic [2:0]     step_ff, step_in;

   logic [10:0] out_ff, skid_ff;
   logic        out_valid_ff, skid_valid_ff;

   logic           accept, restart, digraph, rotate_now;
   logic           build_busy;
   pfr_fill_type   fill;
   pfr_letter_type first_in, second_in;
   logic [CW-1:0]  period_eff;
   logic [CW:0]    count_next;
   pfr_letter_type rotated_square [CELLS];
   logic [2:0]     row_shift [SIDE];

   logic [CELLS-1:0]                 hit_first, hit_second;
   logic [CELLS-1:0]                 pick_first, pick_second;
   pfr_letter_type [CELLS-1:0]       first_picks, second_picks;
   pfr_target_type                   target;
   pfr_letter_type                   first_out, second_out;
   logic [10:0]                      result;

   function automatic pfr_letter_type norm_letter(input pfr_letter_type code);
      pfr_letter_type norm;
      norm = (code > LETTER_Z) ? LETTER_Z : code;
      if (norm == LETTER_J) begin
         norm = LETTER_I;
      end
      return norm;
   endfunction

   assign req_tready = !build_busy && !skid_valid_ff;
   assign accept = req_tvalid && req_tready;
   assign restart = accept && (req_tuser == CMD_RESTART);
   assign digraph = accept && ((req_tuser == CMD_ENCRYPT) || (req_tuser == CMD_DECRYPT));
   assign first_in = norm_letter(req_tdata[4:0]);
   assign second_in = norm_letter(req_tdata[9:5]);

   pfr_builder u_builder (
      .clock       (clock),
      .reset       (reset),
      .start       (restart),
      .start_keys  ({key_last_ff, key_middle_ff, key_first_ff}),
      .start_order (fill_order_ff),
      .busy        (build_busy),
      .fill        (fill)
   );

   for (genvar k = 0; k < CELLS; k++) begin : g_lane
      assign pick_first[k] = target.row1[k / SIDE] & target.col1[k % SIDE];
      assign pick_second[k] = target.row2[k / SIDE] & target.col2[k % SIDE];
      pfr_lane u_lane (
         .letter      (square_ff[k]),
         .first_in    (first_in),
         .second_in   (second_in),
         .pick_first  (pick_first[k]),
         .pick_second (pick_second[k]),
         .hit_first   (hit_first[k]),
         .hit_second  (hit_second[k]),
         .first_pick  (first_picks[k]),
         .second_pick (second_picks[k])
      );
   end

   pfr_merge u_merge (
      .hit_first    (hit_first),
      .hit_second   (hit_second),
      .decrypt      (req_tuser == CMD_DECRYPT),
      .first_picks  (first_picks),
      .second_picks (second_picks),
      .target       (target),
      .first_out    (first_out),
      .second_out   (second_out)
   );

   always_comb begin
      if (period_ff == '0) begin
         period_eff = CW'(1);
      end else if (32'(period_ff) > MAX_PERIOD) begin
         period_eff = CW'(MAX_PERIOD);
      end else begin
         period_eff = CW'(period_ff);
      end
      count_next = {1'b0, count_ff} + (CW+1)'(1);
      rotate_now = count_next >= {1'b0, period_eff};

      count_in = count_ff;
      step_in = step_ff;
      if (restart) begin
         count_in = '0;
         step_in = '0;
      end else if (digraph) begin
         if (rotate_now) begin
            count_in = '0;
            step_in = (step_ff == 3'd4) ? 3'd0 : step_ff + 3'd1;
         end else begin
            count_in = count_next[CW-1:0];
         end
      end
      result = {rotate_now, second_out, first_out};
   end

   for (genvar r = 0; r < SIDE; r++) begin : g_row
      logic [3:0] shift_sum;
      assign shift_sum = 4'(step_in) + 4'(r);
      assign row_shift[r] = (shift_sum >= 4'd5) ? 3'(shift_sum - 4'd5) : shift_sum[2:0];
      for (genvar c = 0; c < SIDE; c++) begin : g_col
         always_comb begin
            rotated_square[r*SIDE + c] = square_ff[r*SIDE + c];
            for (int s = 0; s < SIDE; s++) begin
               if (row_shift[r] == 3'(s)) begin
                  rotated_square[r*SIDE + c] = square_ff[r*SIDE + ((c + s) % SIDE)];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_first_ff <= KEY_FIRST_RESET;
         key_middle_ff <= KEY_MIDDLE_RESET;
         key_last_ff <= KEY_LAST_RESET;
         fill_order_ff <= ORDER_ROW;
         period_ff <= PERIOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_FIRST:  key_first_ff <= csr_wdata[44:0];
            CSR_KEY_MIDDLE: key_middle_ff <= csr_wdata[44:0];
            CSR_KEY_LAST:   key_last_ff <= csr_wdata[34:0];
            CSR_FILL_ORDER: fill_order_ff <= csr_wdata[1:0];
            CSR_PERIOD:     period_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (fill.wr) begin
         square_ff[fill.slot] <= fill.letter;
      end else if (digraph && rotate_now) begin
         square_ff <= rotated_square;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         step_ff <= '0;
      end else begin
         count_ff <= count_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= digraph;
         end
      end else if (digraph) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_tready) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end else if (digraph) begin
         skid_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {5'b0, out_ff};

endmodule

// ===== src/pfr_checker.sv =====
// ---------------------------------------------------------------------------
// Port checker
// Watches the cipher's ports for stall, build and letter range rules.
// ---------------------------------------------------------------------------
module pfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   import pfr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("Result item dropped while stalled.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("Result item changed while stalled.");

   a_reset_build: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("Input taken while the square is built after reset.");

   a_restart_build: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == CMD_RESTART) |=> !req_tready)
      else $error("Input taken while the square is rebuilt.");

   a_letters: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:0] <= LETTER_Z) && (rsp_tdata[4:0] != LETTER_J)
                     && (rsp_tdata[9:5] <= LETTER_Z) && (rsp_tdata[9:5] != LETTER_J))
      else $error("Result letter outside the square alphabet.");

endmodule

bind rotating_playfair_digraph_cipher pfr_checker u_pfr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
